// File: src/cxy_pkg.sv
`timescale 1ns / 1ps
// Package for the CoreXY move command generator: sequencer states, mode,
// status and register index codes, reset values. No dependencies.
package cxy_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POSX,
    ST_POSY,
    ST_MMX,
    ST_MMY,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DURM,
    ST_DURD,
    ST_HPA,
    ST_HPB,
    ST_DONE
  } state_t;

  localparam logic [1:0] MODE_ABS   = 2'd0;
  localparam logic [1:0] MODE_REL   = 2'd1;
  localparam logic [1:0] MODE_DWELL = 2'd2;
  localparam logic [1:0] MODE_HOME  = 2'd3;

  localparam logic [1:0] STAT_ISSUED = 2'd0;
  localparam logic [1:0] STAT_SLOW   = 2'd1;
  localparam logic [1:0] STAT_HOME   = 2'd2;

  localparam logic [1:0] CFG_STEPS_PER_MM = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_S  = 2'd1;
  localparam logic [1:0] CFG_MIN_VEL      = 2'd2;

  localparam logic [23:0] RST_STEPS_PER_MM = 24'd5804738;
  localparam logic [29:0] RST_TICKS_PER_S  = 30'd200000000;
  localparam logic [15:0] RST_MIN_VEL      = 16'd25;

  localparam logic [30:0] IDLE_PERIOD = 31'h7fff_ffff;
  localparam logic [1:0]  DIR_DEFAULT = 2'b01;

endpackage

// File: src/corexy_move_command_generator_top.sv
`timescale 1ns / 1ps
// CoreXY move command generator: converts move, dwell and home requests into
// A/B half-step periods, duration and direction. Depends on cxy_pkg.
//
// One request is handled at a time. Dwell, home and too-slow requests go
// straight from idle to the done state. Moves use one shared bit-serial
// restoring divider (64 steps a pass: position to mm for x and y on absolute
// moves only, duration, two half periods), one shift-add multiplier (32 steps
// a pass: two mm-to-step products, two squares, duration product) and a
// 32-step digit-by-digit square root. A finished result waits in the output
// register while the next request is accepted.
module corexy_move_command_generator_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [16:0] in_target_x,
  input  logic signed [16:0] in_target_y,
  input  logic [15:0]        in_velocity,
  input  logic [31:0]        in_dwell_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [30:0]        out_a_half_period,
  output logic [30:0]        out_b_half_period,
  output logic [31:0]        out_duration_ticks,
  output logic [31:0]        out_aux_period,
  output logic [1:0]         out_direction_bits,
  output logic signed [31:0] out_position_a,
  output logic signed [31:0] out_position_b,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [29:0]        cfg_wdata
);
  import cxy_pkg::*;

  localparam int SHIFT = FRAC_BITS + 16;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  logic [23:0] spm_r;
  logic [29:0] tps_r;
  logic [15:0] minv_r;
  logic [31:0] abs_a_r, abs_b_r;

  logic signed [16:0] tx_r, ty_r;
  logic [15:0]        vel_r;
  logic               pos_neg_r;
  logic [31:0]        dx_r, dy_r;
  logic signed [36:0] sx_r, sy_r;
  logic [31:0]        da_r, db_r;
  logic [63:0]        sum_r;

  logic [63:0] div_n_r;
  logic [31:0] div_rem_r, div_d_r;
  logic [63:0] mul_a_r, mul_p_r;
  logic [31:0] mul_b_r;
  logic [63:0] sq_n_r;
  logic [35:0] sq_rem_r;
  logic [31:0] sq_root_r;

  logic [1:0]  res_status_r, res_dir_r;
  logic [30:0] res_pa_r, res_pb_r;
  logic [31:0] res_ticks_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r, out_dir_r;
  logic [30:0] out_pa_r, out_pb_r;
  logic [31:0] out_end_r, out_aux_r, out_pos_a_r, out_pos_b_r;

  logic in_fire, out_free, mul_last, div_last, early;

  // shared serial units
  logic [32:0] div_rem_sh;
  logic        div_ge;
  logic [31:0] div_rem_step;
  logic [63:0] div_n_step;
  logic [63:0] mul_p_step;
  logic [35:0] sq_rem_sh, sq_trial;
  logic        sq_ge;
  logic [35:0] sq_rem_step;
  logic [31:0] sq_root_step;

  // operand and result shaping
  logic signed [32:0] pos_diff, pos_sum, pos_sel, pos_half;
  logic [31:0]        pos_mag;
  logic [31:0]        mm_qc;
  logic signed [32:0] mm_val;
  logic signed [33:0] d_diff;
  logic [31:0]        d_clamp;
  logic [31:0]        dx_mag, dy_mag;
  logic [35:0]        st_q;
  logic signed [36:0] st_val;
  logic signed [37:0] da_sum, db_sum;
  logic [31:0]        da_sat, db_sat;
  logic [31:0]        ticks_sat;
  logic [30:0]        da_mag, db_mag;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign mul_last = (cnt_r == 6'd31);
  assign div_last = (cnt_r == 6'd63);
  assign early    = (in_mode == MODE_HOME) || (in_mode == MODE_DWELL) ||
                    (in_velocity <= minv_r);

  assign div_rem_sh   = {div_rem_r, div_n_r[63]};
  assign div_ge       = (div_rem_sh >= {1'b0, div_d_r});
  assign div_rem_step = div_ge ? 32'(div_rem_sh - {1'b0, div_d_r}) : div_rem_sh[31:0];
  assign div_n_step   = {div_n_r[62:0], div_ge};

  assign mul_p_step = mul_p_r + (mul_b_r[0] ? mul_a_r : 64'd0);

  assign sq_rem_sh    = {sq_rem_r[33:0], sq_n_r[63:62]};
  assign sq_trial     = {2'b00, sq_root_r, 2'b01};
  assign sq_ge        = (sq_rem_sh >= sq_trial);
  assign sq_rem_step  = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
  assign sq_root_step = {sq_root_r[30:0], sq_ge};

  always_comb begin
    pos_diff = $signed({abs_a_r[31], abs_a_r}) - $signed({abs_b_r[31], abs_b_r});
    pos_sum  = $signed({abs_a_r[31], abs_a_r}) + $signed({abs_b_r[31], abs_b_r});
    pos_sel  = (state_r == ST_IDLE) ? pos_diff : pos_sum;
    pos_half = $signed(pos_sel + $signed({32'd0, pos_sel[32]})) >>> 1;
    pos_mag  = pos_half[32] ? 32'(-pos_half) : pos_half[31:0];

    mm_qc = (div_n_step > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : div_n_step[31:0];
    if (spm_r == 24'd0) begin
      mm_val = 33'sd0;
    end else if (pos_neg_r) begin
      mm_val = -$signed({1'b0, mm_qc});
    end else if (mm_qc[31]) begin
      mm_val = 33'sh0_7fff_ffff;
    end else begin
      mm_val = $signed({1'b0, mm_qc});
    end
    d_diff = (state_r == ST_POSX) ? $signed({{17{tx_r[16]}}, tx_r}) :
                                    $signed({{17{ty_r[16]}}, ty_r});
    d_diff = d_diff - $signed({mm_val[32], mm_val});
    if (d_diff[33:31] == 3'b000 || d_diff[33:31] == 3'b111) begin
      d_clamp = d_diff[31:0];
    end else begin
      d_clamp = d_diff[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    end

    dx_mag = dx_r[31] ? (32'd0 - dx_r) : dx_r;
    dy_mag = dy_r[31] ? (32'd0 - dy_r) : dy_r;

    st_q   = 36'(mul_p_step >> SHIFT);
    st_val = ((state_r == ST_MMX) ? dx_r[31] : dy_r[31]) ? -$signed({1'b0, st_q}) :
                                                          $signed({1'b0, st_q});

    da_sum = $signed({sy_r[36], sy_r}) + $signed({sx_r[36], sx_r});
    db_sum = $signed({sy_r[36], sy_r}) - $signed({sx_r[36], sx_r});
    if (da_sum > 38'sd2147483647) begin
      da_sat = 32'h7fff_ffff;
    end else if (da_sum < -38'sd2147483647) begin
      da_sat = 32'h8000_0001;
    end else begin
      da_sat = da_sum[31:0];
    end
    if (db_sum > 38'sd2147483647) begin
      db_sat = 32'h7fff_ffff;
    end else if (db_sum < -38'sd2147483647) begin
      db_sat = 32'h8000_0001;
    end else begin
      db_sat = db_sum[31:0];
    end

    ticks_sat = (div_n_step[63:32] != 32'd0) ? 32'hffff_ffff : div_n_step[31:0];
    da_mag    = da_r[31] ? 31'(32'd0 - da_r) : da_r[30:0];
    db_mag    = db_r[31] ? 31'(32'd0 - db_r) : db_r[30:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (early) begin
            state_nxt = ST_DONE;
          end else if (in_mode == MODE_ABS) begin
            state_nxt = ST_POSX;
          end else begin
            state_nxt = ST_MMX;
          end
        end
      end
      ST_POSX: if (div_last) state_nxt = ST_POSY;
      ST_POSY: if (div_last) state_nxt = ST_MMX;
      ST_MMX:  if (mul_last) state_nxt = ST_MMY;
      ST_MMY:  if (mul_last) state_nxt = ST_SQX;
      ST_SQX:  if (mul_last) state_nxt = ST_SQY;
      ST_SQY:  if (mul_last) state_nxt = ST_SQRT;
      ST_SQRT: if (mul_last) state_nxt = ST_DURM;
      ST_DURM: if (mul_last) state_nxt = ST_DURD;
      ST_DURD: if (div_last) state_nxt = ST_HPA;
      ST_HPA:  if (div_last) state_nxt = ST_HPB;
      ST_HPB:  if (div_last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_nxt != state_r || state_r == ST_IDLE || state_r == ST_DONE) begin
      cnt_nxt = 6'd0;
    end else begin
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // configuration, position state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r       <= RST_STEPS_PER_MM;
      tps_r       <= RST_TICKS_PER_S;
      minv_r      <= RST_MIN_VEL;
      abs_a_r     <= 32'd0;
      abs_b_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEPS_PER_MM: spm_r  <= cfg_wdata[23:0];
          CFG_TICKS_PER_S:  tps_r  <= cfg_wdata;
          CFG_MIN_VEL:      minv_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_fire && in_mode == MODE_HOME) begin
        abs_a_r <= 32'd0;
        abs_b_r <= 32'd0;
      end else if (state_r == ST_HPB && div_last) begin
        abs_a_r <= abs_a_r + da_r;
        abs_b_r <= abs_b_r + db_r;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: serial unit steps, operand loads at each phase end
  always_ff @(posedge clk) begin
    div_n_r   <= div_n_step;
    div_rem_r <= div_rem_step;
    mul_p_r   <= mul_p_step;
    mul_a_r   <= {mul_a_r[62:0], 1'b0};
    mul_b_r   <= {1'b0, mul_b_r[31:1]};
    sq_n_r    <= {sq_n_r[61:0], 2'b00};
    sq_rem_r  <= sq_rem_step;
    sq_root_r <= sq_root_step;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          tx_r         <= in_target_x;
          ty_r         <= in_target_y;
          vel_r        <= in_velocity;
          dx_r         <= {{15{in_target_x[16]}}, in_target_x};
          dy_r         <= {{15{in_target_y[16]}}, in_target_y};
          res_status_r <= STAT_ISSUED;
          res_pa_r     <= IDLE_PERIOD;
          res_pb_r     <= IDLE_PERIOD;
          res_ticks_r  <= 32'd0;
          res_dir_r    <= 2'b00;
          if (in_mode == MODE_HOME) begin
            res_status_r <= STAT_HOME;
          end else if (in_mode == MODE_DWELL) begin
            res_ticks_r <= in_dwell_ticks;
            res_dir_r   <= DIR_DEFAULT;
          end else if (in_velocity <= minv_r) begin
            res_status_r <= STAT_SLOW;
          end
          // x position load, or first product of a relative move
          div_n_r   <= 64'(pos_mag) << SHIFT;
          div_rem_r <= 32'd0;
          div_d_r   <= {8'd0, spm_r};
          pos_neg_r <= pos_half[32];
          mul_p_r   <= 64'd0;
          mul_a_r   <= {32'd0, (in_target_x[16] ? 32'd0 - 32'(in_target_x) :
                                                  32'(in_target_x))};
          mul_b_r   <= {8'd0, spm_r};
        end
      end
      ST_POSX: begin
        if (div_last) begin
          dx_r      <= d_clamp;
          div_n_r   <= 64'(pos_mag) << SHIFT;
          div_rem_r <= 32'd0;
          pos_neg_r <= pos_half[32];
        end
      end
      ST_POSY: begin
        if (div_last) begin
          dy_r    <= d_clamp;
          mul_p_r <= 64'd0;
          mul_a_r <= {32'd0, dx_mag};
          mul_b_r <= {8'd0, spm_r};
        end
      end
      ST_MMX: begin
        if (mul_last) begin
          sx_r    <= st_val;
          mul_p_r <= 64'd0;
          mul_a_r <= {32'd0, dy_mag};
          mul_b_r <= {8'd0, spm_r};
        end
      end
      ST_MMY: begin
        if (mul_last) begin
          sy_r    <= st_val;
          mul_p_r <= 64'd0;
          mul_a_r <= {32'd0, dx_mag};
          mul_b_r <= dx_mag;
        end
      end
      ST_SQX: begin
        if (mul_last) begin
          sum_r   <= mul_p_step;
          mul_p_r <= 64'd0;
          mul_a_r <= {32'd0, dy_mag};
          mul_b_r <= dy_mag;
        end
      end
      ST_SQY: begin
        if (mul_last) begin
          da_r      <= da_sat;
          db_r      <= db_sat;
          sq_n_r    <= sum_r + mul_p_step;
          sq_rem_r  <= 36'd0;
          sq_root_r <= 32'd0;
        end
      end
      ST_SQRT: begin
        if (mul_last) begin
          mul_p_r <= 64'd0;
          mul_a_r <= {34'd0, tps_r};
          mul_b_r <= sq_root_step;
        end
      end
      ST_DURM: begin
        if (mul_last) begin
          div_n_r   <= mul_p_step;
          div_rem_r <= 32'd0;
          div_d_r   <= {16'd0, vel_r};
        end
      end
      ST_DURD: begin
        if (div_last) begin
          res_ticks_r <= ticks_sat;
          res_dir_r   <= {db_r[31], ~da_r[31]};
          div_n_r     <= {32'd0, ticks_sat};
          div_rem_r   <= 32'd0;
          div_d_r     <= {da_mag, 1'b0};
        end
      end
      ST_HPA: begin
        if (div_last) begin
          res_pa_r  <= (da_r == 32'd0) ? IDLE_PERIOD : div_n_step[30:0];
          div_n_r   <= {32'd0, res_ticks_r};
          div_rem_r <= 32'd0;
          div_d_r   <= {db_mag, 1'b0};
        end
      end
      ST_HPB: begin
        if (div_last) begin
          res_pb_r <= (db_r == 32'd0) ? IDLE_PERIOD : div_n_step[30:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_pa_r     <= res_pa_r;
          out_pb_r     <= res_pb_r;
          out_end_r    <= res_ticks_r;
          out_aux_r    <= (res_status_r == STAT_ISSUED) ? res_ticks_r + 32'd1 : 32'd0;
          out_dir_r    <= res_dir_r;
          out_pos_a_r  <= abs_a_r;
          out_pos_b_r  <= abs_b_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_a_half_period  = out_pa_r;
  assign out_b_half_period  = out_pb_r;
  assign out_duration_ticks = out_end_r;
  assign out_aux_period     = out_aux_r;
  assign out_direction_bits = out_dir_r;
  assign out_position_a     = out_pos_a_r;
  assign out_position_b     = out_pos_b_r;

  a_aux_follows_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_ISSUED) |-> out_aux_r == out_end_r + 32'd1)
    else $error("aux period does not follow duration");

  a_no_motion_when_not_issued : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_ISSUED) |->
      (out_pa_r == IDLE_PERIOD && out_pb_r == IDLE_PERIOD && out_end_r == 32'd0))
    else $error("rejected or home transfer carries motion");

  a_position_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_HPB && !(in_fire && in_mode == MODE_HOME)) |=>
      ($stable(abs_a_r) && $stable(abs_b_r)))
    else $error("position changed outside move completion or home");

  a_counter_parked : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> cnt_r == 6'd0)
    else $error("step counter running outside a unit phase");

endmodule
